FILE: rtl/core/psched_pkg.sv
package psched_pkg;

    typedef enum logic [2:0] {
        MODE_ADD_THREAD  = 3'd0,
        MODE_ADD_PERIOD  = 3'd1,
        MODE_START       = 3'd2,
        MODE_TICK        = 3'd3,
        MODE_SLEEP       = 3'd4,
        MODE_KILL_ID     = 3'd5,
        MODE_KILL_SELF   = 3'd6,
        MODE_SET_BLOCKED = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_LAST      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NOT_START = 3'd5
    } t_status;

    localparam int unsigned ID_SHIFT = 16;
    localparam logic [8:0]  NO_PRIORITY = 9'd256;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  priority_req;
        logic [31:0] time_value;
        logic [31:0] thread_id;
        logic        blocked_flag;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [2:0]  running_slot;
        logic [31:0] running_id;
        logic [31:0] new_id;
        logic        event_fired;
        logic [2:0]  event_index;
        logic [31:0] current_time;
        logic        last;
    } t_result;

endpackage

FILE: rtl/core/priority_thread_scheduler_core.sv
// Thread scheduler over a ring of MAX_SLOTS thread slots and MAX_EVENTS periodic
// events. Requests enter a two-beat command queue and are carried out by a
// sequencer that touches one slot or one event per cycle unless a waiting result
// stalls it, so the cost of a request is set by those scans: an add or a request
// refused up front needs no scan, start scans all MAX_SLOTS slots, a kill by id or
// set_blocked searches up to MAX_SLOTS slots for the id and then reschedules once
// started, and a reschedule walks the live threads and then the MAX_EVENTS events.
// A tick scans the events, then every slot for wake-ups, then reschedules; fired
// event beats do not slow it while results are taken at once, and each waiting
// beat stalls the scan. Results leave through a one-beat output register; a tick
// gives one result beat per fired event, in event order, before its final beat.
module priority_thread_scheduler_core #(
    parameter int unsigned MAX_SLOTS  = 8,
    parameter int unsigned MAX_EVENTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_thread_id,
    input  logic        i_blocked_flag,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [2:0]  o_running_slot,
    output logic [31:0] o_running_id,
    output logic [31:0] o_new_id,
    output logic        o_event_fired,
    output logic [2:0]  o_event_index,
    output logic [31:0] o_current_time,
    output logic        o_last
);
    import psched_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_take;
    logic    w_res_valid;
    t_result w_res;

    psched_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_mode         (i_mode),
        .i_priority_req (i_priority_req),
        .i_time_value   (i_time_value),
        .i_thread_id    (i_thread_id),
        .i_blocked_flag (i_blocked_flag),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_take     (w_cmd_take),
        .o_cmd          (w_cmd)
    );

    psched_back #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_take  (pop),
        .o_res       (w_res)
    );

    assign empty          = !w_res_valid;
    assign o_status       = w_res.status;
    assign o_running_slot = w_res.running_slot;
    assign o_running_id   = w_res.running_id;
    assign o_new_id       = w_res.new_id;
    assign o_event_fired  = w_res.event_fired;
    assign o_event_index  = w_res.event_index;
    assign o_current_time = w_res.current_time;
    assign o_last         = w_res.last;

endmodule

FILE: rtl/core/psched_front.sv
module psched_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_priority_req,
    input  logic [31:0]       i_time_value,
    input  logic [31:0]       i_thread_id,
    input  logic              i_blocked_flag,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output psched_pkg::t_cmd  o_cmd
);
    import psched_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       c_wr;
    logic       c_rd;
    t_cmd       c_in;

    always_comb begin
        c_in.mode         = t_mode'(i_mode);
        c_in.priority_req = i_priority_req;
        c_in.time_value   = i_time_value;
        c_in.thread_id    = i_thread_id;
        c_in.blocked_flag = i_blocked_flag;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign c_wr        = i_push && !o_full;
    assign c_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_q[r_wp] <= c_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_wr) r_wp <= !r_wp;
            if (c_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(c_wr) - 2'(c_rd);
        end
    end

endmodule

FILE: rtl/core/psched_back.sv
module psched_back #(
    parameter int unsigned MAX_SLOTS  = 8,
    parameter int unsigned MAX_EVENTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_take,
    input  psched_pkg::t_cmd     i_cmd,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output psched_pkg::t_result  o_res
);
    import psched_pkg::*;

    localparam int unsigned SW  = $clog2(MAX_SLOTS);
    localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned EW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int unsigned ECW = $clog2(MAX_EVENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_EVT, S_WAKE, S_FIND, S_RPREP, S_RESCH, S_FIRE, S_DONE
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    t_status         r_status;
    logic [31:0]     r_newid;
    logic [2:0]      r_idx;

    logic [MAX_SLOTS-1:0] r_alive;
    logic [MAX_SLOTS-1:0] r_asleep;
    logic [MAX_SLOTS-1:0] r_blocked;
    logic [7:0]      r_prio  [MAX_SLOTS];
    logic [31:0]     r_wake  [MAX_SLOTS];
    logic [31:0]     r_ident [MAX_SLOTS];
    logic [SW-1:0]   r_next  [MAX_SLOTS];
    logic [SW-1:0]   r_prev  [MAX_SLOTS];
    logic [CW-1:0]   r_live;
    logic [15:0]     r_idcnt;
    logic [SW-1:0]   r_run;
    logic            r_started;
    logic [31:0]     r_tick;
    logic [ECW-1:0]  r_ecnt;
    logic [31:0]     r_period [MAX_EVENTS];
    logic [31:0]     r_due    [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] r_fired;

    logic [CW-1:0]   r_i;
    logic [ECW-1:0]  r_e;
    logic [8:0]      r_best;
    logic [SW-1:0]   r_pick;
    logic            r_found;
    logic [SW-1:0]   r_walk;

    logic            r_ov;
    t_result         r_out;

    logic            c_out_free;
    logic            c_emit;
    logic [SW-1:0]   c_free;
    logic            c_free_any;
    logic [SW-1:0]   c_head;
    logic [SW-1:0]   c_si;
    logic            c_take;
    t_status         c_status;
    t_state          c_go;

    always_comb begin
        c_free     = '0;
        c_free_any = 1'b0;
        c_head     = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (!r_alive[k]) begin
                c_free     = SW'(k);
                c_free_any = 1'b1;
            end else begin
                c_head = SW'(k);
            end
        end
    end

    // Outcome of the command at the head of the queue and the step that carries it out.
    always_comb begin
        c_status = ST_OK;
        c_go     = S_DONE;
        unique case (i_cmd.mode)
            MODE_ADD_THREAD: begin
                if (r_live == CW'(MAX_SLOTS)) c_status = ST_LIMIT;
                else if (!c_free_any) c_status = ST_NO_SLOT;
            end
            MODE_ADD_PERIOD: begin
                if (r_ecnt == ECW'(MAX_EVENTS)) c_status = ST_LIMIT;
            end
            MODE_START: begin
                if (!r_started) begin
                    if (r_live == '0) c_status = ST_NOT_FOUND;
                    else c_go = S_START;
                end
            end
            MODE_TICK: begin
                if (!r_started) c_status = ST_NOT_START;
                else c_go = S_EVT;
            end
            MODE_SLEEP: begin
                if (!r_started) c_status = ST_NOT_START;
                else c_go = S_RPREP;
            end
            MODE_KILL_ID: begin
                if (r_live == CW'(1)) c_status = ST_LAST;
                else c_go = S_FIND;
            end
            MODE_KILL_SELF: begin
                if (!r_started) c_status = ST_NOT_START;
                else if (r_live == CW'(1)) c_status = ST_LAST;
                else c_go = S_RPREP;
            end
            MODE_SET_BLOCKED: c_go = S_FIND;
            default: c_go = S_DONE;
        endcase
    end

    assign c_si       = r_i[SW-1:0];
    assign c_out_free = !r_ov || i_res_take;
    assign c_emit     = c_out_free &&
                        ((r_state == S_DONE) ||
                         ((r_state == S_FIRE) && (r_e != ECW'(MAX_EVENTS)) &&
                          r_fired[r_e[EW-1:0]]));
    assign o_cmd_take = (r_state == S_IDLE);
    assign o_res_valid = r_ov;
    assign o_res      = r_out;
    // Candidate test shared by the start scan and the ring walk.
    assign c_take     = (r_state == S_START) ?
                        (r_alive[c_si] && ({1'b0, r_prio[c_si]} < r_best)) :
                        (r_alive[r_walk] && !r_asleep[r_walk] && !r_blocked[r_walk] &&
                         ({1'b0, r_prio[r_walk]} < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alive   <= '0;
            r_asleep  <= '0;
            r_blocked <= '0;
            r_live    <= '0;
            r_idcnt   <= '0;
            r_run     <= '0;
            r_started <= 1'b0;
            r_tick    <= '0;
            r_ecnt    <= '0;
            r_fired   <= '0;
            r_ov      <= 1'b0;
            for (int k = 0; k < MAX_SLOTS; k++) r_wake[k] <= '0;
        end else begin
            r_ov <= c_emit || (r_ov && !i_res_take);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_status <= c_status;
                        r_newid  <= (i_cmd.mode == MODE_ADD_THREAD && c_status == ST_OK) ?
                                    {r_idcnt, 16'(c_free)} : 32'd0;
                        r_idx    <= (i_cmd.mode == MODE_ADD_PERIOD && c_status == ST_OK) ?
                                    3'(r_ecnt) : 3'd0;
                        r_i      <= '0;
                        r_e      <= '0;
                        r_best   <= NO_PRIORITY;
                        r_pick   <= '0;
                        r_state  <= c_go;
                        if (c_status == ST_OK) begin
                            unique case (i_cmd.mode)
                                MODE_ADD_THREAD: begin
                                    if (r_live == '0) begin
                                        r_next[c_free] <= c_free;
                                        r_prev[c_free] <= c_free;
                                    end else if (r_started) begin
                                        r_prev[c_free]      <= r_run;
                                        r_next[c_free]      <= r_next[r_run];
                                        r_next[r_run]       <= c_free;
                                        r_prev[r_next[r_run]] <= c_free;
                                    end else begin
                                        r_prev[c_free]        <= r_prev[c_head];
                                        r_next[c_free]        <= c_head;
                                        r_next[r_prev[c_head]] <= c_free;
                                        r_prev[c_head]        <= c_free;
                                    end
                                    r_asleep[c_free]  <= 1'b0;
                                    r_wake[c_free]    <= '0;
                                    r_blocked[c_free] <= 1'b0;
                                    r_prio[c_free]    <= i_cmd.priority_req;
                                    r_ident[c_free]   <= {r_idcnt, 16'(c_free)};
                                    r_idcnt           <= r_idcnt + 16'd1;
                                    r_alive[c_free]   <= 1'b1;
                                    r_live            <= r_live + CW'(1);
                                end
                                MODE_ADD_PERIOD: begin
                                    r_period[r_ecnt[EW-1:0]] <= i_cmd.time_value;
                                    r_due[r_ecnt[EW-1:0]]    <= r_tick + i_cmd.time_value;
                                    r_ecnt <= r_ecnt + ECW'(1);
                                end
                                MODE_TICK: begin
                                    r_tick  <= r_tick + 32'd1;
                                    r_fired <= '0;
                                end
                                MODE_SLEEP: begin
                                    r_wake[r_run]   <= r_tick + i_cmd.time_value;
                                    r_asleep[r_run] <= 1'b1;
                                end
                                MODE_KILL_SELF: begin
                                    r_prev[r_next[r_run]] <= r_prev[r_run];
                                    r_next[r_prev[r_run]] <= r_next[r_run];
                                    r_alive[r_run]        <= 1'b0;
                                    r_live                <= r_live - CW'(1);
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_START: begin
                    if (c_take) begin
                        r_best <= {1'b0, r_prio[c_si]};
                        r_pick <= c_si;
                    end
                    r_i <= r_i + CW'(1);
                    if (r_i == CW'(MAX_SLOTS - 1)) begin
                        r_run     <= c_take ? c_si : r_pick;
                        r_started <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_EVT: begin
                    if (r_e >= r_ecnt) begin
                        r_i     <= '0;
                        r_state <= S_WAKE;
                    end else begin
                        if (r_due[r_e[EW-1:0]] <= r_tick) begin
                            r_due[r_e[EW-1:0]]   <= r_tick + r_period[r_e[EW-1:0]];
                            r_fired[r_e[EW-1:0]] <= 1'b1;
                        end
                        r_e <= r_e + ECW'(1);
                    end
                end
                S_WAKE: begin
                    if (r_asleep[c_si] && r_wake[c_si] <= r_tick) begin
                        r_asleep[c_si] <= 1'b0;
                        r_wake[c_si]   <= '0;
                    end
                    r_i <= r_i + CW'(1);
                    if (r_i == CW'(MAX_SLOTS - 1)) r_state <= S_RPREP;
                end
                S_FIND: begin
                    if (r_alive[c_si] && r_ident[c_si] == r_cmd.thread_id) begin
                        if (r_cmd.mode == MODE_KILL_ID) begin
                            r_prev[r_next[c_si]] <= r_prev[c_si];
                            r_next[r_prev[c_si]] <= r_next[c_si];
                            r_alive[c_si]        <= 1'b0;
                            r_live               <= r_live - CW'(1);
                        end else begin
                            r_blocked[c_si] <= r_cmd.blocked_flag;
                        end
                        r_state <= r_started ? S_RPREP : S_DONE;
                    end else if (r_i == CW'(MAX_SLOTS - 1)) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end
                    r_i <= r_i + CW'(1);
                end
                S_RPREP: begin
                    // Links written by an unlink in the previous cycle are settled here.
                    r_walk  <= r_next[r_run];
                    r_i     <= '0;
                    r_best  <= NO_PRIORITY;
                    r_found <= 1'b0;
                    r_pick  <= r_run;
                    r_state <= S_RESCH;
                end
                S_RESCH: begin
                    if (r_i >= r_live) begin
                        if (r_found) r_run <= r_pick;
                        else if (!r_alive[r_run]) r_run <= r_next[r_run];
                        r_e     <= '0;
                        r_state <= S_FIRE;
                    end else begin
                        if (c_take) begin
                            r_best  <= {1'b0, r_prio[r_walk]};
                            r_pick  <= r_walk;
                            r_found <= 1'b1;
                        end
                        r_walk <= r_next[r_walk];
                        r_i    <= r_i + CW'(1);
                    end
                end
                S_FIRE: begin
                    if (r_e == ECW'(MAX_EVENTS)) begin
                        r_state <= S_DONE;
                    end else if (!r_fired[r_e[EW-1:0]]) begin
                        r_e <= r_e + ECW'(1);
                    end else if (c_out_free) begin
                        r_out.status          <= ST_OK;
                        r_out.running_slot    <= 3'(r_run);
                        r_out.running_id      <= r_ident[r_run];
                        r_out.new_id          <= '0;
                        r_out.event_fired     <= 1'b1;
                        r_out.event_index     <= 3'(r_e);
                        r_out.current_time    <= r_tick;
                        r_out.last            <= 1'b0;
                        r_fired[r_e[EW-1:0]]  <= 1'b0;
                        r_e                   <= r_e + ECW'(1);
                    end
                end
                S_DONE: begin
                    if (c_out_free) begin
                        r_out.status       <= r_status;
                        r_out.running_slot <= r_started ? 3'(r_run) : 3'd0;
                        r_out.running_id   <= r_started ? r_ident[r_run] : 32'd0;
                        r_out.new_id       <= r_newid;
                        r_out.event_fired  <= 1'b0;
                        r_out.event_index  <= r_idx;
                        r_out.current_time <= r_tick;
                        r_out.last         <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(MAX_SLOTS))
        else $error("live thread count exceeds the slot table");
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_alive) == int'(r_live)))
        else $error("live thread count disagrees with the alive flags");
    a_run_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_started) |-> r_alive[r_run])
        else $error("running slot is not a live thread");
`endif

endmodule

FILE: test/priority_thread_scheduler_core_tb.sv
`timescale 1ns / 100ps

module priority_thread_scheduler_core_tb;
    import psched_pkg::*;

    localparam int SLOTS      = 8;
    localparam int EVENTS     = 8;
    localparam int RAND_ITEMS = 340;
    localparam int PHASE_LEN  = 90;
    localparam int WDOG_LIMIT = 5000;

    typedef struct {
        t_mode       mode;
        logic [7:0]  prio;
        logic [31:0] tval;
        logic [31:0] tid;
        logic        bflag;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_mode = '0;
    logic [7:0]  i_priority_req = '0;
    logic [31:0] i_time_value = '0;
    logic [31:0] i_thread_id = '0;
    logic        i_blocked_flag = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_running_slot;
    logic [31:0] o_running_id;
    logic [31:0] o_new_id;
    logic        o_event_fired;
    logic [2:0]  o_event_index;
    logic [31:0] o_current_time;
    logic        o_last;

    priority_thread_scheduler_core uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scheduler mirror.
    logic        alive [SLOTS];
    logic        asleep [SLOTS];
    logic        blk [SLOTS];
    logic [7:0]  prio [SLOTS];
    logic [31:0] wake [SLOTS];
    logic [31:0] ident [SLOTS];
    int          nxt [SLOTS];
    int          prv [SLOTS];
    int          n_live;
    logic [15:0] id_ctr;
    int          run_slot;
    logic        running;
    logic [31:0] ticks;
    int          n_events;
    logic [31:0] ev_period [EVENTS];
    logic [31:0] ev_due [EVENTS];

    t_request pending_reqs[$];
    t_result  expected_beats[$];
    t_request cur_req;

    int n_accepted = 0;
    int n_beats = 0;
    int n_fired = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    function automatic int phase();
        return n_accepted / PHASE_LEN;
    endfunction

    function automatic void pick_next_runner();
        int  walk;
        int  best;
        int  pick;
        bit  found;
        walk = nxt[run_slot];
        best = 256;
        pick = run_slot;
        found = 0;
        for (int i = 0; i < n_live; i++) begin
            if (alive[walk] && !asleep[walk] && !blk[walk] && prio[walk] < best) begin
                pick = walk;
                best = prio[walk];
                found = 1;
            end
            walk = nxt[walk];
        end
        if (!found && !alive[run_slot])
            pick = nxt[run_slot];
        run_slot = pick;
    endfunction

    function automatic void remove_slot(int s);
        prv[nxt[s]] = prv[s];
        nxt[prv[s]] = nxt[s];
        alive[s] = 0;
        n_live--;
    endfunction

    function automatic int slot_of_id(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (alive[i] && ident[i] == id)
                return i;
        return -1;
    endfunction

    function automatic t_result make_beat(t_status st, logic fired, int idx,
                                          logic [31:0] nid, logic lst);
        t_result r;
        r.status       = st;
        r.running_slot = running ? 3'(run_slot) : 3'd0;
        r.running_id   = running ? ident[run_slot] : 32'd0;
        r.new_id       = nid;
        r.event_fired  = fired;
        r.event_index  = 3'(idx);
        r.current_time = ticks;
        r.last         = lst;
        return r;
    endfunction

    function automatic void schedule_request(t_request rq);
        t_status     st;
        int          idx;
        logic [31:0] nid;
        int          fired_q[$];
        int          s;
        int          best;
        st = ST_OK;
        idx = 0;
        nid = '0;
        case (rq.mode)
            MODE_ADD_THREAD: begin
                if (n_live >= SLOTS) begin
                    st = ST_LIMIT;
                end else begin
                    s = 0;
                    while (alive[s]) s++;
                    if (n_live == 0) begin
                        nxt[s] = s;
                        prv[s] = s;
                    end else if (running) begin
                        prv[s] = run_slot;
                        nxt[s] = nxt[run_slot];
                        prv[nxt[run_slot]] = s;
                        nxt[run_slot] = s;
                    end else begin
                        int h;
                        h = 0;
                        while (!alive[h]) h++;
                        prv[s] = prv[h];
                        nxt[s] = h;
                        nxt[prv[h]] = s;
                        prv[h] = s;
                    end
                    asleep[s] = 0;
                    wake[s] = '0;
                    blk[s] = 0;
                    prio[s] = rq.prio;
                    ident[s] = {id_ctr, 16'(s)};
                    id_ctr++;
                    alive[s] = 1;
                    n_live++;
                    nid = ident[s];
                end
            end
            MODE_ADD_PERIOD: begin
                if (n_events >= EVENTS) begin
                    st = ST_LIMIT;
                end else begin
                    ev_period[n_events] = rq.tval;
                    ev_due[n_events] = ticks + rq.tval;
                    idx = n_events;
                    n_events++;
                end
            end
            MODE_START: begin
                if (!running) begin
                    if (n_live == 0) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        best = 256;
                        for (int i = 0; i < SLOTS; i++)
                            if (alive[i] && prio[i] < best) begin
                                best = prio[i];
                                run_slot = i;
                            end
                        running = 1;
                    end
                end
            end
            MODE_TICK: begin
                if (!running) begin
                    st = ST_NOT_START;
                end else begin
                    ticks++;
                    for (int i = 0; i < n_events; i++)
                        if (ev_due[i] <= ticks) begin
                            ev_due[i] = ticks + ev_period[i];
                            fired_q.push_back(i);
                        end
                    for (int i = 0; i < SLOTS; i++)
                        if (asleep[i] && wake[i] <= ticks) begin
                            asleep[i] = 0;
                            wake[i] = '0;
                        end
                    pick_next_runner();
                end
            end
            MODE_SLEEP: begin
                if (!running) begin
                    st = ST_NOT_START;
                end else begin
                    wake[run_slot] = ticks + rq.tval;
                    asleep[run_slot] = 1;
                    pick_next_runner();
                end
            end
            MODE_KILL_ID: begin
                if (n_live == 1) begin
                    st = ST_LAST;
                end else begin
                    s = slot_of_id(rq.tid);
                    if (s < 0) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        remove_slot(s);
                        if (running) pick_next_runner();
                    end
                end
            end
            MODE_KILL_SELF: begin
                if (!running) begin
                    st = ST_NOT_START;
                end else if (n_live == 1) begin
                    st = ST_LAST;
                end else begin
                    remove_slot(run_slot);
                    pick_next_runner();
                end
            end
            default: begin
                s = slot_of_id(rq.tid);
                if (s < 0) begin
                    st = ST_NOT_FOUND;
                end else begin
                    blk[s] = rq.bflag;
                    if (running) pick_next_runner();
                end
            end
        endcase
        foreach (fired_q[i])
            expected_beats.push_back(make_beat(ST_OK, 1'b1, fired_q[i], '0, 1'b0));
        n_fired += fired_q.size();
        expected_beats.push_back(make_beat(st, 1'b0, idx, nid, 1'b1));
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
            n_errors++;
        end
    endfunction

    // Driver: the beat on the ports is taken at this edge if push is high and full is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            bit taken;
            bit idle;
            taken = push && !full;
            if (taken) begin
                schedule_request(cur_req);
                n_accepted++;
            end
            if (taken || !push) begin
                idle = (phase() == 1) ? ($urandom_range(99) < 75) :
                       (phase() >= 3) ? ($urandom_range(99) < 18) : 1'b0;
                if (pending_reqs.size() > 0 && !idle) begin
                    cur_req = pending_reqs.pop_front();
                    push <= 1'b1;
                    i_mode <= cur_req.mode;
                    i_priority_req <= cur_req.prio;
                    i_time_value <= cur_req.tval;
                    i_thread_id <= cur_req.tid;
                    i_blocked_flag <= cur_req.bflag;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor and stall generator for the result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_beats++;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d time %0h",
                             $time, o_status, o_current_time);
                    n_errors++;
                end else begin
                    t_result e;
                    e = expected_beats.pop_front();
                    check_field("status", e.status, o_status);
                    check_field("running_slot", e.running_slot, o_running_slot);
                    check_field("running_id", e.running_id, o_running_id);
                    check_field("new_id", e.new_id, o_new_id);
                    check_field("event_fired", e.event_fired, o_event_fired);
                    check_field("event_index", e.event_index, o_event_index);
                    check_field("current_time", e.current_time, o_current_time);
                    check_field("last", e.last, o_last);
                end
            end
            if (phase() == 2)
                pop <= ($urandom_range(99) >= 75);
            else if (phase() >= 3)
                pop <= ($urandom_range(99) >= 18);
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_request req(t_mode m, int p, logic [31:0] tv,
                                     logic [31:0] id, bit bf);
        t_request r;
        r.mode = m;
        r.prio = 8'(p);
        r.tval = tv;
        r.tid = id;
        r.bflag = bf;
        return r;
    endfunction

    // Picks the id held by a random slot, live or not, most of the time so that kills and blocks land.
    function automatic logic [31:0] some_id();
        int s;
        if ($urandom_range(9) == 0)
            return $urandom();
        s = $urandom_range(SLOTS - 1);
        return ident[s];
    endfunction

    function automatic t_request random_request();
        int          w;
        logic [31:0] tv;
        w = $urandom_range(99);
        tv = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(6);
        if (n_live < 3 && w < 60)
            return req(MODE_ADD_THREAD, $urandom_range(255), 0, 0, 0);
        if (w < 35)
            return req(MODE_TICK, 0, tv, 0, 0);
        if (w < 48)
            return req(MODE_ADD_THREAD, ($urandom_range(1)) ? $urandom_range(3) :
                       $urandom_range(255), tv, $urandom(), $urandom_range(1));
        if (w < 58)
            return req(MODE_SLEEP, 0, tv, 0, 0);
        if (w < 67)
            return req(MODE_KILL_ID, 0, 0, some_id(), 0);
        if (w < 72)
            return req(MODE_KILL_SELF, 0, 0, 0, 0);
        if (w < 88)
            return req(MODE_SET_BLOCKED, 0, 0, some_id(), $urandom_range(2) == 0);
        if (w < 94)
            return req(MODE_ADD_PERIOD, 0, ($urandom_range(3) == 0) ? $urandom() :
                       $urandom_range(1, 5), 0, 0);
        return req(MODE_START, $urandom_range(255), tv, $urandom(), $urandom_range(1));
    endfunction

    initial begin
        foreach (alive[i]) begin
            alive[i] = 0;
            asleep[i] = 0;
            blk[i] = 0;
            prio[i] = '0;
            wake[i] = '0;
            ident[i] = '0;
            nxt[i] = 0;
            prv[i] = 0;
        end
        foreach (ev_period[i]) begin
            ev_period[i] = '0;
            ev_due[i] = '0;
        end
        n_live = 0;
        id_ctr = '0;
        run_slot = 0;
        running = 0;
        ticks = '0;
        n_events = 0;

        // Requests before any thread exists or the scheduler runs.
        pending_reqs.push_back(req(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SLEEP, 0, 32'hFFFF_FFFF, 0, 0));
        pending_reqs.push_back(req(MODE_KILL_SELF, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_START, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_KILL_ID, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SET_BLOCKED, 0, 0, 32'hFFFF_FFFF, 1));
        // Three threads with a priority tie, then events that wrap time.
        pending_reqs.push_back(req(MODE_ADD_THREAD, 255, 0, 0, 0));
        pending_reqs.push_back(req(MODE_ADD_THREAD, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_ADD_THREAD, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_ADD_PERIOD, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_ADD_PERIOD, 0, 32'hFFFF_FFFF, 0, 0));
        pending_reqs.push_back(req(MODE_ADD_PERIOD, 0, 2, 0, 0));
        pending_reqs.push_back(req(MODE_START, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_START, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SLEEP, 0, 3, 0, 0));
        pending_reqs.push_back(req(MODE_SET_BLOCKED, 0, 0, 32'h0001_0001, 1));
        pending_reqs.push_back(req(MODE_TICK, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_KILL_ID, 0, 0, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(req(MODE_KILL_ID, 0, 0, 32'h0000_0000, 0));
        pending_reqs.push_back(req(MODE_KILL_SELF, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_KILL_SELF, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_KILL_ID, 0, 0, 32'h0002_0002, 0));
        pending_reqs.push_back(req(MODE_SET_BLOCKED, 0, 0, 32'h0001_0001, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random requests are made just ahead of the driver so that ids follow the mirror.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            while (pending_reqs.size() > 1) @(posedge i_clk);
            pending_reqs.push_back(random_request());
        end

        while (pending_reqs.size() > 0 || push) @(posedge i_clk);
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("%0d requests, %0d result beats, %0d event firings, final tick %0d",
                 n_accepted, n_beats, n_fired, ticks);
        $display("covered four flow-control phases and all eight request kinds");
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
